/* rtl/rau_pkg.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared widths, operation codes and derived constants for the unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  // Operand width: each operand is the two's complement value of its low OPW bits.
  localparam int unsigned OPW       = 32;
  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned RES_W     = 64;
  localparam int unsigned FUNC_W    = 3;
  localparam int unsigned CNT_W     = $clog2(OPW);

  // Stream data widths, padded to whole bytes.
  localparam int unsigned S_TDATA_W = ((FUNC_W + 4 * FIELD_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = 2 * RES_W;

  // Operation codes.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 3'd0,
    FUNC_SUB    = 3'd1,
    FUNC_MUL    = 3'd2,
    FUNC_DIV    = 3'd3,
    FUNC_REDUCE = 3'd4
  } func_e;

endpackage

/* rtl/rau_gcd.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit: GCD reduction
// Binary GCD of two non-zero magnitudes, then both are divided by the GCD
// with two restoring dividers, one quotient bit per cycle each.
// ----------------------------------------------------------------------------
module rau_gcd
  import rau_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [OPW-1:0] x_i,
  input  logic [OPW-1:0] y_i,
  output logic           done_o,
  output logic [OPW-1:0] qx_o,
  output logic [OPW-1:0] qy_o
);

  typedef enum logic [3:0] {
    G_IDLE = 4'b0001,
    G_STEP = 4'b0010,
    G_DIV  = 4'b0100,
    G_DONE = 4'b1000
  } gstate_e;

  gstate_e state_q, state_d;

  logic [OPW-1:0]   u_q, u_d, v_q, v_d;
  logic [CNT_W-1:0] k_q, k_d, cnt_q, cnt_d;
  logic [OPW-1:0]   g_q, g_d;
  logic [OPW-1:0]   nx_q, nx_d, ny_q, ny_d;
  logic [OPW-1:0]   rx_q, rx_d, ry_q, ry_d;

  logic             uv_ge;
  logic [OPW-1:0]   diff;
  logic [OPW:0]     trial_x, trial_y, g_ext;
  logic             ge_x, ge_y;

  // Shared subtractor of the GCD iteration: larger minus smaller.
  assign uv_ge = (u_q >= v_q);
  assign diff  = uv_ge ? (u_q - v_q) : (v_q - u_q);

  // Trial subtraction of the restoring dividers.
  assign g_ext   = {1'b0, g_q};
  assign trial_x = {rx_q, nx_q[OPW-1]};
  assign trial_y = {ry_q, ny_q[OPW-1]};
  assign ge_x    = (trial_x >= g_ext);
  assign ge_y    = (trial_y >= g_ext);

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_d = state_q;
    u_d     = u_q;
    v_d     = v_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    g_d     = g_q;
    nx_d    = nx_q;
    ny_d    = ny_q;
    rx_d    = rx_q;
    ry_d    = ry_q;
    unique case (state_q)
      G_IDLE: begin
        if (start_i) begin
          u_d     = x_i;
          v_d     = y_i;
          nx_d    = x_i;
          ny_d    = y_i;
          k_d     = '0;
          state_d = G_STEP;
        end
      end
      G_STEP: begin
        priority if ((u_q == '0) || (v_q == '0)) begin
          g_d     = (u_q | v_q) << k_q;
          rx_d    = '0;
          ry_d    = '0;
          cnt_d   = '0;
          state_d = G_DIV;
        end else if (!u_q[0] && !v_q[0]) begin
          u_d = u_q >> 1;
          v_d = v_q >> 1;
          k_d = k_q + 1'b1;
        end else if (!u_q[0]) begin
          u_d = u_q >> 1;
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
        end else if (uv_ge) begin
          u_d = diff >> 1;
        end else begin
          v_d = diff >> 1;
        end
      end
      G_DIV: begin
        rx_d  = ge_x ? OPW'(trial_x - g_ext) : trial_x[OPW-1:0];
        ry_d  = ge_y ? OPW'(trial_y - g_ext) : trial_y[OPW-1:0];
        nx_d  = {nx_q[OPW-2:0], ge_x};
        ny_d  = {ny_q[OPW-2:0], ge_y};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(OPW - 1)) begin
          state_d = G_DONE;
        end
      end
      G_DONE: begin
        state_d = G_IDLE;
      end
      default: begin
        state_d = G_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    u_q   <= u_d;
    v_q   <= v_d;
    k_q   <= k_d;
    cnt_q <= cnt_d;
    g_q   <= g_d;
    nx_q  <= nx_d;
    ny_q  <= ny_d;
    rx_q  <= rx_d;
    ry_q  <= ry_d;
  end

  assign done_o = (state_q == G_DONE);
  assign qx_o   = nx_q;
  assign qy_o   = ny_q;

endmodule

/* rtl/rational_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies, divides or reduces signed fractions.
// ----------------------------------------------------------------------------
// One item is taken at a time. Add and subtract form three products and then a sum
// before the output register, multiply and divide form two products, and items
// with a zero denominator, a zero divisor or an unused code go straight to it; the
// products come from one shared signed multiplier used once per product. Reduce
// runs the binary GCD iteration (at most about 2*OPW steps) followed by OPW
// restoring-division steps. The next item is accepted while a finished result
// waits on the output.
module rational_arithmetic_unit
  import rau_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input stream.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata from bit 0: func[3], a_num[32], a_den[32], b_num[32], b_den[32], zero pad.
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // Output stream.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tdata from bit 0: res_num[64], res_den[64].
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // tuser: status[1], set on a zero denominator or a zero divisor.
  output logic                 m_axis_tuser
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL0 = 7'b0000010,
    S_MUL1 = 7'b0000100,
    S_MUL2 = 7'b0001000,
    S_SUM  = 7'b0010000,
    S_GCD  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Input field extraction.
  logic [FUNC_W-1:0]    in_func;
  logic signed [OPW-1:0] in_an, in_ad, in_bn, in_bd;
  logic [OPW-1:0]        mag_an, mag_ad;

  assign in_func = s_axis_tdata[FUNC_W-1:0];
  assign in_an   = s_axis_tdata[FUNC_W + 0 * FIELD_W +: OPW];
  assign in_ad   = s_axis_tdata[FUNC_W + 1 * FIELD_W +: OPW];
  assign in_bn   = s_axis_tdata[FUNC_W + 2 * FIELD_W +: OPW];
  assign in_bd   = s_axis_tdata[FUNC_W + 3 * FIELD_W +: OPW];

  // Magnitudes for reduce; the most negative value maps onto its unsigned magnitude.
  assign mag_an = in_an[OPW-1] ? OPW'(~in_an + 1'b1) : OPW'(in_an);
  assign mag_ad = in_ad[OPW-1] ? OPW'(~in_ad + 1'b1) : OPW'(in_ad);

  // Held operands and working registers.
  func_e                 func_q, func_d;
  logic signed [OPW-1:0] an_q, an_d, ad_q, ad_d, bn_q, bn_d, bd_q, bd_d;
  logic [RES_W-1:0]      acc_q, acc_d, den_q, den_d, prod_q, prod_d;
  logic                  st_q, st_d, neg_q, neg_d;

  // Output register.
  logic [RES_W-1:0] out_num_q, out_num_d, out_den_q, out_den_d;
  logic             out_st_q, out_st_d, out_vld_q, out_vld_d;

  logic in_xfer, gcd_start, gcd_done;
  logic [OPW-1:0] gcd_qx, gcd_qy;
  logic [RES_W-1:0] red_num;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign gcd_start     = in_xfer && (in_func == FUNC_REDUCE) &&
                         (in_ad != '0) && (in_an != '0);

  // Shared signed multiplier.
  logic signed [OPW-1:0]   mul_a, mul_b;
  logic signed [2*OPW-1:0] mul_p;
  logic [RES_W-1:0]        mul_ext;

  always_comb begin
    mul_a = an_q;
    mul_b = bd_q;
    unique case (state_q)
      S_MUL0: begin
        mul_a = an_q;
        mul_b = (func_q == FUNC_MUL) ? bn_q : bd_q;
      end
      S_MUL1: begin
        mul_a = ad_q;
        mul_b = (func_q == FUNC_DIV) ? bn_q : bd_q;
      end
      S_MUL2: begin
        mul_a = bn_q;
        mul_b = ad_q;
      end
      default: begin
        mul_a = an_q;
        mul_b = bd_q;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign mul_ext = RES_W'(mul_p);

  // GCD reduction unit.
  rau_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .x_i     (mag_an),
    .y_i     (mag_ad),
    .done_o  (gcd_done),
    .qx_o    (gcd_qx),
    .qy_o    (gcd_qy)
  );

  assign red_num = neg_q ? (~RES_W'(gcd_qx) + 1'b1) : RES_W'(gcd_qx);

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    func_d    = func_q;
    an_d      = an_q;
    ad_d      = ad_q;
    bn_d      = bn_q;
    bd_d      = bd_q;
    acc_d     = acc_q;
    den_d     = den_q;
    prod_d    = prod_q;
    st_d      = st_q;
    neg_d     = neg_q;
    out_num_d = out_num_q;
    out_den_d = out_den_q;
    out_st_d  = out_st_q;
    out_vld_d = out_vld_q;

    // The output register empties on an output transfer.
    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          func_d = func_e'(in_func);
          an_d   = in_an;
          ad_d   = in_ad;
          bn_d   = in_bn;
          bd_d   = in_bd;
          neg_d  = in_an[OPW-1] ^ in_ad[OPW-1];
          st_d   = 1'b0;
          acc_d  = '0;
          den_d  = '0;
          unique case (in_func)
            FUNC_ADD, FUNC_SUB, FUNC_MUL: begin
              if ((in_ad == '0) || (in_bd == '0)) begin
                st_d    = 1'b1;
                state_d = S_OUT;
              end else begin
                state_d = S_MUL0;
              end
            end
            FUNC_DIV: begin
              if ((in_ad == '0) || (in_bd == '0) || (in_bn == '0)) begin
                st_d    = 1'b1;
                state_d = S_OUT;
              end else begin
                state_d = S_MUL0;
              end
            end
            FUNC_REDUCE: begin
              priority if (in_ad == '0) begin
                st_d    = 1'b1;
                state_d = S_OUT;
              end else if (in_an == '0) begin
                den_d   = RES_W'(mag_ad);
                state_d = S_OUT;
              end else begin
                state_d = S_GCD;
              end
            end
            default: begin
              // Unused codes give zero over one.
              den_d   = RES_W'(1);
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_MUL0: begin
        acc_d   = mul_ext;
        state_d = S_MUL1;
      end
      S_MUL1: begin
        den_d   = mul_ext;
        state_d = ((func_q == FUNC_ADD) || (func_q == FUNC_SUB)) ? S_MUL2 : S_OUT;
      end
      S_MUL2: begin
        prod_d  = mul_ext;
        state_d = S_SUM;
      end
      S_SUM: begin
        acc_d   = (func_q == FUNC_SUB) ? (acc_q - prod_q) : (acc_q + prod_q);
        state_d = S_OUT;
      end
      S_GCD: begin
        if (gcd_done) begin
          acc_d   = red_num;
          den_d   = RES_W'(gcd_qy);
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // Load the output register once it is free.
        if (!out_vld_q || m_axis_tready) begin
          out_num_d = acc_q;
          out_den_d = den_q;
          out_st_d  = st_q;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    an_q      <= an_d;
    ad_q      <= ad_d;
    bn_q      <= bn_d;
    bd_q      <= bd_d;
    acc_q     <= acc_d;
    den_q     <= den_d;
    prod_q    <= prod_d;
    st_q      <= st_d;
    neg_q     <= neg_d;
    out_num_q <= out_num_d;
    out_den_q <= out_den_d;
    out_st_q  <= out_st_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_den_q, out_num_q};
  assign m_axis_tuser  = out_st_q;

endmodule

/* verif/rational_arithmetic_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives fraction operations into the input stream and checks every output
// transfer, field by field, against a fraction predictor held in this bench.
// Covers directed corner cases, random mixes, reduce items with planted common
// factors, a long output stall and a final stretch with no idling.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 128;
  localparam int REPORT_LIMIT  = 10;

  // Codes outside the operation set; the unit must answer them with 0 over 1.
  localparam logic [FUNC_W-1:0] FUNC_FIRST_UNUSED = FUNC_W'(FUNC_REDUCE + 1);
  localparam logic [FUNC_W-1:0] FUNC_LAST_UNUSED  = '1;

  // Operand extremes.
  localparam logic [FIELD_W-1:0] OPD_MAX      = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam logic [FIELD_W-1:0] OPD_MOST_NEG = {1'b1, {(FIELD_W-1){1'b0}}};
  localparam logic [FIELD_W-1:0] OPD_MIN      = OPD_MOST_NEG + 1;
  localparam logic [FIELD_W-1:0] OPD_MINUS1   = '1;

  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [FIELD_W-1:0] a_num;
    logic [FIELD_W-1:0] a_den;
    logic [FIELD_W-1:0] b_num;
    logic [FIELD_W-1:0] b_den;
  } fraction_op_t;

  typedef struct {
    logic [RES_W-1:0] num;
    logic [RES_W-1:0] den;
    logic             status;
  } fraction_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;

  fraction_t pending_fractions[$];
  int        cycle_count    = 0;
  int        mismatch_count = 0;
  int        items_sent     = 0;
  int        results_seen   = 0;
  int        reduce_items   = 0;
  int        fault_items    = 0;
  bit        src_idle_en    = 1'b0;
  bit        sink_idle_en   = 1'b0;
  int        hold_reqs      = 0;
  int        holds_served   = 0;
  int        hold_left      = 0;
  int        stall_left     = 0;

  rational_arithmetic_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Works out the fraction the unit should return for one operation.
  function automatic fraction_t predict_fraction(fraction_op_t op);
    fraction_t         r;
    longint            an, ad, bn, bd;
    longint unsigned   mn, md, x, y, t;
    r.num    = '0;
    r.den    = '0;
    r.status = 1'b0;
    an = $signed(op.a_num);
    ad = $signed(op.a_den);
    bn = $signed(op.b_num);
    bd = $signed(op.b_den);
    case (op.func)
      FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV: begin
        if (ad == 0 || bd == 0 || (op.func == FUNC_DIV && bn == 0)) begin
          r.status = 1'b1;
        end else begin
          case (op.func)
            FUNC_ADD: begin
              r.num = an * bd + bn * ad;
              r.den = ad * bd;
            end
            FUNC_SUB: begin
              r.num = an * bd - bn * ad;
              r.den = ad * bd;
            end
            FUNC_MUL: begin
              r.num = an * bn;
              r.den = ad * bd;
            end
            default: begin
              r.num = an * bd;
              r.den = ad * bn;
            end
          endcase
        end
      end
      FUNC_REDUCE: begin
        if (ad == 0) begin
          r.status = 1'b1;
        end else begin
          mn = (an < 0) ? -an : an;
          md = (ad < 0) ? -ad : ad;
          if (mn == 0) begin
            r.den = md;
          end else begin
            // Euclid on the magnitudes, then the sign goes on the numerator.
            x = mn;
            y = md;
            while (y != 0) begin
              t = x % y;
              x = y;
              y = t;
            end
            mn = mn / x;
            r.num = ((an < 0) != (ad < 0)) ? -mn : mn;
            r.den = md / x;
          end
        end
      end
      default: begin
        r.den = RES_W'(1);
      end
    endcase
    return r;
  endfunction

  function automatic logic [S_TDATA_W-1:0] pack_operation(fraction_op_t op);
    logic [S_TDATA_W-1:0] d;
    d = '0;
    d[0 +: FUNC_W]                   = op.func;
    d[FUNC_W +: FIELD_W]             = op.a_num;
    d[FUNC_W + FIELD_W +: FIELD_W]   = op.a_den;
    d[FUNC_W + 2*FIELD_W +: FIELD_W] = op.b_num;
    d[FUNC_W + 3*FIELD_W +: FIELD_W] = op.b_den;
    return d;
  endfunction

  function automatic fraction_op_t make_op(logic [FUNC_W-1:0] f, logic [FIELD_W-1:0] an,
                                           logic [FIELD_W-1:0] ad, logic [FIELD_W-1:0] bn,
                                           logic [FIELD_W-1:0] bd);
    fraction_op_t op;
    op.func  = f;
    op.a_num = an;
    op.a_den = ad;
    op.b_num = bn;
    op.b_den = bd;
    return op;
  endfunction

  // Operand values weighted towards zero, unit values, small values and extremes.
  function automatic logic [FIELD_W-1:0] random_operand();
    int small_val;
    small_val = int'($urandom_range(0, 200)) - 100;
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return $urandom_range(0, 1) ? OPD_MINUS1 : FIELD_W'(1);
      2, 3:    return FIELD_W'(small_val);
      4: begin
        case ($urandom_range(0, 2))
          0:       return OPD_MAX;
          1:       return OPD_MIN;
          default: return OPD_MOST_NEG;
        endcase
      end
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  // Denominators are zero only now and then, so that most items do real work.
  function automatic logic [FIELD_W-1:0] random_denominator();
    logic [FIELD_W-1:0] v;
    v = random_operand();
    if (v == '0 && $urandom_range(0, 3) != 0) begin
      v = FIELD_W'(1);
    end
    return v;
  endfunction

  // Reduce operand pair sharing a planted factor, each side with a random sign.
  function automatic fraction_op_t random_reduce_op();
    fraction_op_t    op;
    longint          g, p, q;
    g = $urandom_range(1, 65535);
    p = $urandom_range(0, 32767);
    q = $urandom_range(1, 32767);
    op = make_op(FUNC_REDUCE, FIELD_W'(g * p), FIELD_W'(g * q), random_operand(),
                 random_operand());
    if ($urandom_range(0, 1)) begin
      op.a_num = -op.a_num;
    end
    if ($urandom_range(0, 1)) begin
      op.a_den = -op.a_den;
    end
    if ($urandom_range(0, 19) == 0) begin
      op.a_den = '0;
    end
    return op;
  endfunction

  function automatic fraction_op_t random_op();
    fraction_op_t op;
    op = make_op(FUNC_W'($urandom_range(FUNC_ADD, FUNC_REDUCE)), random_operand(),
                 random_denominator(), random_operand(), random_denominator());
    if ($urandom_range(0, 11) == 0) begin
      op.func = FUNC_W'($urandom_range(FUNC_FIRST_UNUSED, FUNC_LAST_UNUSED));
    end else if (op.func == FUNC_REDUCE && $urandom_range(0, 1)) begin
      op = random_reduce_op();
    end
    return op;
  endfunction

  // Offers one operation, with an optional gap first, and waits for its transfer.
  task automatic send_operation(fraction_op_t op);
    fraction_t want;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tdata  <= pack_operation(op);
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    want = predict_fraction(op);
    pending_fractions.push_back(want);
    items_sent++;
    if (op.func == FUNC_REDUCE) begin
      reduce_items++;
    end
    if (want.status) begin
      fault_items++;
    end
  endtask

  // The sender stops offering and waits until every expected result is home.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending_fractions.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_cases();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    // Plain arithmetic and an integer right operand.
    send_operation(make_op(FUNC_ADD, 1, 2, 1, 3));
    send_operation(make_op(FUNC_SUB, 1, 2, 5, 1));
    send_operation(make_op(FUNC_MUL, -3, 4, 5, -7));
    send_operation(make_op(FUNC_DIV, 2, 3, -4, 5));
    // Reduce: sign handling and a zero numerator.
    send_operation(make_op(FUNC_REDUCE, 6, -4, 0, 0));
    send_operation(make_op(FUNC_REDUCE, -6, -4, OPD_MAX, OPD_MOST_NEG));
    send_operation(make_op(FUNC_REDUCE, 0, -5, 1, 1));
    send_operation(make_op(FUNC_REDUCE, OPD_MOST_NEG, OPD_MOST_NEG, 0, 0));
    send_operation(make_op(FUNC_REDUCE, OPD_MAX, OPD_MIN, 0, 0));
    // Zero denominators and a zero divisor.
    send_operation(make_op(FUNC_ADD, 7, 0, 1, 1));
    send_operation(make_op(FUNC_MUL, 7, 3, 1, 0));
    send_operation(make_op(FUNC_DIV, 7, 3, 0, 9));
    send_operation(make_op(FUNC_SUB, 0, 0, 0, 0));
    send_operation(make_op(FUNC_REDUCE, 5, 0, 1, 1));
    // Unused codes.
    send_operation(make_op(FUNC_FIRST_UNUSED, 3, 4, 5, 6));
    send_operation(make_op(FUNC_W'(FUNC_FIRST_UNUSED + 1), OPD_MAX, 0, 0, 0));
    send_operation(make_op(FUNC_LAST_UNUSED, OPD_MINUS1, OPD_MINUS1, OPD_MINUS1,
                           OPD_MINUS1));
    // Widest products, including the wrap of the most negative operand.
    send_operation(make_op(FUNC_MUL, OPD_MAX, OPD_MAX, OPD_MAX, OPD_MAX));
    send_operation(make_op(FUNC_ADD, OPD_MIN, OPD_MAX, OPD_MIN, OPD_MAX));
    send_operation(make_op(FUNC_ADD, OPD_MOST_NEG, OPD_MOST_NEG, OPD_MOST_NEG,
                           OPD_MOST_NEG));
    send_operation(make_op(FUNC_SUB, OPD_MAX, OPD_MIN, OPD_MIN, OPD_MAX));
    send_operation(make_op(FUNC_DIV, OPD_MIN, OPD_MAX, OPD_MOST_NEG, OPD_MIN));
    wait_for_results();
  endtask

  task automatic test_random_mix(int count);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    repeat (count) send_operation(random_op());
  endtask

  task automatic test_reduce_factors(int count);
    repeat (count) begin
      if ($urandom_range(0, 4) == 0) begin
        send_operation(random_op());
      end else begin
        send_operation(random_reduce_op());
      end
    end
    wait_for_results();
  endtask

  // The receiver holds off for a long stretch while items keep coming, then the
  // sender pauses until every result is home.
  task automatic test_output_backpressure();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    hold_reqs++;
    repeat (24) send_operation(random_op());
    wait_for_results();
  endtask

  task automatic test_unstalled_stream(int count);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    repeat (count) send_operation(random_op());
  endtask

  // Receiver readiness: a requested long hold, random stall bursts, or ready.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (holds_served != hold_reqs) begin
      holds_served  = hold_reqs;
      hold_left     = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      stall_left    = $urandom_range(0, 13);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each output transfer with the oldest expected fraction.
  always @(posedge clk_i) begin : check_results
    fraction_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_fractions.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("ERROR: unexpected result num=%0d den=%0d status=%0b",
                   $signed(m_axis_tdata[0 +: RES_W]), $signed(m_axis_tdata[RES_W +: RES_W]),
                   m_axis_tuser);
        end
      end else begin
        want = pending_fractions.pop_front();
        if (m_axis_tdata[0 +: RES_W] !== want.num || m_axis_tdata[RES_W +: RES_W] !== want.den
            || m_axis_tuser !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("ERROR: result %0d expected %0d/%0d status %0b, got %0d/%0d status %0b",
                     results_seen, $signed(want.num), $signed(want.den), want.status,
                     $signed(m_axis_tdata[0 +: RES_W]), $signed(m_axis_tdata[RES_W +: RES_W]),
                     m_axis_tuser);
          end
        end
      end
    end
  end

  // Give up after a generous number of cycles.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding", cycle_count,
             pending_fractions.size());
    $display("rational_arithmetic_unit verification failed");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_mix(400);
    test_reduce_factors(150);
    test_output_backpressure();
    test_unstalled_stream(180);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    mismatch_count += pending_fractions.size();

    $display("Sent %0d operations and checked %0d results in %0d cycles.", items_sent,
             results_seen, cycle_count);
    $display("Of these, %0d were reduce operations and %0d hit a zero denominator or divisor.",
             reduce_items, fault_items);
    if (mismatch_count == 0) begin
      $display("rational_arithmetic_unit verification clean");
    end else begin
      $display("%0d mismatches in total", mismatch_count);
      $display("rational_arithmetic_unit verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/rau_pkg.sv
rtl/rau_gcd.sv
rtl/rational_arithmetic_unit.sv
verif/rational_arithmetic_unit_tb.sv
